>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for concurrent checks on clk, with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that is masked while arst_n is low
`define C2D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// check that also holds while reset is applied
`define C2D_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared constants, types and helpers of the 3x3 convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package c2d_pkg;

	localparam int KERNEL_SIZE = 3;
	localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
	localparam int MAX_COLS    = 2048;
	localparam int MAX_ROWS    = 4096;

	localparam int PIX_W  = 8;
	localparam int ROW_W  = 12;
	localparam int COL_W  = 11;
	localparam int COEF_W = 16;
	localparam int SUM_W  = 28;
	localparam int PROD_W = COEF_W + PIX_W + 1;

	localparam int ROWS_REG_W = 13;
	localparam int COLS_REG_W = 12;
	localparam int COEF_ROW_W = COEF_W * KERNEL_SIZE;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_ROW_W;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MID   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT   = 3'd4;

	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 13'd480;
	localparam logic [COLS_REG_W-1:0] COLS_RESET = 12'd640;

	// pixel after the line-store lookup, entering the window
	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} c2d_pix_t;

	// one result on its way down the MAC chain
	typedef struct packed {
		logic                      valid;
		logic [ROW_W-1:0]          row;
		logic [COL_W-1:0]          col;
		logic                      last;
		logic signed [SUM_W-1:0]   sum;
		logic [TAPS-1:0][PIX_W-1:0] tap;
	} c2d_beat_t;

	// last row index: clamp(v, 2, MAX_ROWS) - 1
	function automatic logic [ROW_W-1:0] rows_last(input logic [ROWS_REG_W-1:0] v);
		logic [ROWS_REG_W-1:0] t;
		begin
			if (v < ROWS_REG_W'(2)) t = ROWS_REG_W'(2);
			else if (v > ROWS_REG_W'(MAX_ROWS)) t = ROWS_REG_W'(MAX_ROWS);
			else t = v;
			rows_last = ROW_W'(t - ROWS_REG_W'(1));
		end
	endfunction

	// last column index: clamp(v, 2, MAX_COLS) - 1
	function automatic logic [COL_W-1:0] cols_last(input logic [COLS_REG_W-1:0] v);
		logic [COLS_REG_W-1:0] t;
		begin
			if (v < COLS_REG_W'(2)) t = COLS_REG_W'(2);
			else if (v > COLS_REG_W'(MAX_COLS)) t = COLS_REG_W'(MAX_COLS);
			else t = v;
			cols_last = COL_W'(t - COLS_REG_W'(1));
		end
	endfunction

endpackage

`default_nettype wire

>>> sv/c2d_ram.sv
// ----------------------------------------------------------------------------
// c2d_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> sv/c2d_mac_cell.sv
// ----------------------------------------------------------------------------
// c2d_mac_cell
// One tap of the MAC chain: adds coef * tap to the running sum, passes on.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_mac_cell
	import c2d_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic [COEF_W-1:0]       coef,
	input  wire logic [PIX_W-1:0]        tap,
	input  wire c2d_beat_t               din,
	output c2d_beat_t                    dout
);

	logic signed [PROD_W-1:0] prod;
	logic                     valid_q;
	c2d_beat_t                data_q;
	c2d_beat_t                data_nxt;

	assign prod = PROD_W'($signed(coef) * $signed({1'b0, tap}));

	// beat as it leaves this cell: running sum grown by this tap
	always_comb begin
		data_nxt     = din;
		data_nxt.sum = din.sum + SUM_W'(prod);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_nxt;
		end
	end

	always_comb begin
		dout       = data_q;
		dout.valid = valid_q;
	end

endmodule

`default_nettype wire

>>> sv/c2d_jobgen.sv
// ----------------------------------------------------------------------------
// c2d_jobgen
// 3x3 window of column cells and the sequencer that issues up to four
// results per pixel, each from a shifted, zero-filled view of the window.
// ----------------------------------------------------------------------------
`default_nettype none

module c2d_jobgen
	import c2d_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire c2d_pix_t         din,
	input  wire logic [ROW_W-1:0] last_row,
	input  wire logic [COL_W-1:0] last_col,
	output logic                  take,
	output logic                  multi,
	output c2d_beat_t             job
);

	// pending results: 0 own, 1 right edge, 2 bottom edge, 3 corner
	logic [3:0]       pend_q;
	logic [3:0]       low;
	logic [3:0]       mask;
	logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];
	logic [ROW_W-1:0] rm1_q;
	logic [COL_W-1:0] cm1_q;
	logic             dr;
	logic             dc;

	assign low   = pend_q & (~pend_q + 4'd1);
	assign multi = (pend_q & (pend_q - 4'd1)) != 4'd0;
	assign take  = !multi;
	assign dr    = low[2] | low[3];
	assign dc    = low[1] | low[3];

	always_comb begin
		mask[0] = (din.row != '0) && (din.col != '0);
		mask[1] = (din.row != '0) && (din.col == last_col);
		mask[2] = (din.row == last_row) && (din.col != '0);
		mask[3] = (din.row == last_row) && (din.col == last_col);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (en) begin
			if (take) begin
				pend_q <= din.valid ? mask : 4'd0;
			end else begin
				pend_q <= pend_q & ~low;
			end
		end
	end

	// window columns shift left, cleared at a row's first pixel; column 2 takes the new pixel column
	always_ff @(posedge clk) begin
		if (en && take && din.valid) begin
			rm1_q <= din.row - ROW_W'(1);
			cm1_q <= din.col - COL_W'(1);
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				win_q[i][0] <= (din.col == '0) ? '0 : win_q[i][1];
				win_q[i][1] <= (din.col == '0) ? '0 : win_q[i][2];
			end
			win_q[0][2] <= din.top;
			win_q[1][2] <= din.mid;
			win_q[2][2] <= din.px;
		end
	end

	always_comb begin
		job       = '0;
		job.valid = pend_q != 4'd0;
		job.row   = dr ? last_row : rm1_q;
		job.col   = dc ? last_col : cm1_q;
		job.last  = (pend_q & ~low) == 4'd0;
		job.sum   = '0;
		for (int a = 0; a < KERNEL_SIZE; a++) begin
			for (int b = 0; b < KERNEL_SIZE; b++) begin
				if ((2 - a + int'(dr) < KERNEL_SIZE) && (2 - b + int'(dc) < KERNEL_SIZE)) begin
					job.tap[a * KERNEL_SIZE + b] = win_q[2 - a + int'(dr)][2 - b + int'(dc)];
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/conv2d_3x3_zero_padded.sv
// ----------------------------------------------------------------------------
// conv2d_3x3_zero_padded
// Streaming 3x3 true convolution with zero padding, same-size output frame.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// s_*     | in  | tdata[7:0] pixel, raster order
// m_*     | out | tdata[11:0] out_row, [22:12] out_col, [50:23] value; tlast
// cfg_*   | in  | cfg_index selects register, cfg_data written when cfg_we
//
// One pixel per cycle while s_tready is high. A pixel that closes a row or sits
// in the last row causes extra results; these pass one by one through the shared
// 9-cell MAC chain, so such a pixel holds s_tready low while they are issued.
// A pixel passes the line-store read, the window and 9 MAC cells, the last of
// which is the output register.
// Reset clears control state; line stores are never cleared, rows above row 0
// are masked to zero. m_tready low while a result waits freezes the whole chain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module conv2d_3x3_zero_padded
	import c2d_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // pixel[7:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [55:0]                m_tdata,   // out_row, out_col, value, zero pad
	output logic                       m_tlast,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CA_W = $clog2(MAX_COLS);

	logic [ROWS_REG_W-1:0] frame_rows_q;
	logic [COLS_REG_W-1:0] frame_cols_q;
	logic [COEF_ROW_W-1:0] coef_q [KERNEL_SIZE];
	logic [ROW_W-1:0]      last_row;
	logic [COL_W-1:0]      last_col;

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;

	logic             adv;       // MAC chain and output register move
	logic             up_adv;    // front end moves
	logic             take;
	logic             multi;
	logic             s_accept;

	logic             v_s1;
	logic [PIX_W-1:0] px_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic [2*PIX_W-1:0] line_rd;  // [7:0] row above, [15:8] two rows above

	c2d_pix_t  pix;
	c2d_beat_t chain [TAPS+1];

	assign last_row = rows_last(frame_rows_q);
	assign last_col = cols_last(frame_cols_q);

	assign adv      = !chain[TAPS].valid || m_tready;
	assign up_adv   = adv && take;
	assign s_tready = up_adv;
	assign s_accept = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q <= ROWS_RESET;
			frame_cols_q <= COLS_RESET;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_ROWS: frame_rows_q <= cfg_data[ROWS_REG_W-1:0];
				REG_FRAME_COLS: frame_cols_q <= cfg_data[COLS_REG_W-1:0];
				REG_COEF_TOP:   coef_q[0] <= cfg_data;
				REG_COEF_MID:   coef_q[1] <= cfg_data;
				REG_COEF_BOT:   coef_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster position of the next pixel; a size write restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we && (cfg_index == REG_FRAME_ROWS || cfg_index == REG_FRAME_COLS)) begin
			row_q <= '0;
			col_q <= '0;
		end else if (s_accept) begin
			if (col_q == last_col) begin
				col_q <= '0;
				row_q <= (row_q == last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// stage 1: line-store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (up_adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_adv) begin
			px_s1  <= s_tdata;
			row_s1 <= row_q;
			col_s1 <= col_q;
		end
	end

	// both line stores share one RAM word per column; a pixel shifts them down
	c2d_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_COLS)
	) u_line (
		.clk   (clk),
		.we    (up_adv && v_s1),
		.waddr (col_s1[CA_W-1:0]),
		.wdata ({line_rd[PIX_W-1:0], px_s1}),
		.re    (up_adv),
		.raddr (col_q[CA_W-1:0]),
		.rdata (line_rd)
	);

	always_comb begin
		pix.valid = v_s1;
		pix.px    = px_s1;
		pix.mid   = (row_s1 >= ROW_W'(1)) ? line_rd[PIX_W-1:0] : '0;
		pix.top   = (row_s1 >= ROW_W'(2)) ? line_rd[2*PIX_W-1:PIX_W] : '0;
		pix.row   = row_s1;
		pix.col   = col_s1;
	end

	c2d_jobgen u_jobgen (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.din      (pix),
		.last_row (last_row),
		.last_col (last_col),
		.take     (take),
		.multi    (multi),
		.job      (chain[0])
	);

	// MAC chain: cell k handles mask row k/3, column k%3
	for (genvar k = 0; k < TAPS; k++) begin : g_cell
		c2d_mac_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.coef   (coef_q[k / KERNEL_SIZE][(k % KERNEL_SIZE) * COEF_W +: COEF_W]),
			.tap    (chain[k].tap[k]),
			.din    (chain[k]),
			.dout   (chain[k+1])
		);
	end

	assign m_tvalid = chain[TAPS].valid;
	assign m_tlast  = chain[TAPS].last;
	assign m_tdata  = {5'd0, chain[TAPS].sum, chain[TAPS].col, chain[TAPS].row};

	`C2D_ASSERT(a_no_take_while_multi, s_tready |-> !multi,
		"input taken while several results still queued")
	`C2D_ASSERT(a_col_wrap, (s_accept && col_q == last_col && !cfg_we) |=> (col_q == '0),
		"column did not wrap at row end")
	`C2D_ASSERT(a_out_col_range, m_tvalid |-> (m_tdata[22:12] <= last_col),
		"result column beyond frame")
	`C2D_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid,
		"output valid during reset")

endmodule

`default_nettype wire
